### rtl/salsa_keystream_xor_core_macros.svh
// ----------------------------------------------------------------------------
// salsa keystream xor core assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SALSA_KEYSTREAM_XOR_CORE_MACROS_SVH
`define SALSA_KEYSTREAM_XOR_CORE_MACROS_SVH

// same-cycle implication
`define SKX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/skx_pkg.sv
// ----------------------------------------------------------------------------
// skx_pkg
// shared constants, types and the block-word builder for the keystream core
// ----------------------------------------------------------------------------
package skx_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DR_W          = $clog2(DOUBLE_ROUNDS + 1);

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam logic [4:0] ROT_NONE = 5'd0;
    localparam logic [4:0] ROT_B    = 5'd7;
    localparam logic [4:0] ROT_C    = 5'd9;
    localparam logic [4:0] ROT_D    = 5'd13;
    localparam logic [4:0] ROT_A    = 5'd18;

    // quarter-round sub-steps, named after the word they update
    localparam logic [1:0] STEP_B = 2'd0;
    localparam logic [1:0] STEP_C = 2'd1;
    localparam logic [1:0] STEP_D = 2'd2;
    localparam logic [1:0] STEP_A = 2'd3;

    typedef logic [7:0][31:0]  key_arr_t;
    typedef logic [15:0][31:0] word_arr_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_STEP,
        OP_FEED
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] step;
        logic       q_last;
        logic       h_last;
        logic [3:0] f_idx;
    } ctrl_t;

    // initial block word for a given slot
    function automatic logic [31:0] init_word(input logic [3:0]  idx,
                                              input key_arr_t    key,
                                              input logic [63:0] off);
        logic [31:0] w;
        case (idx)
            4'd0:    w = SIGMA0;
            4'd1:    w = key[0];
            4'd2:    w = key[1];
            4'd3:    w = key[2];
            4'd4:    w = key[3];
            4'd5:    w = SIGMA1;
            4'd6:    w = off[63:32];
            4'd7:    w = off[31:0];
            4'd8:    w = off[63:32];
            4'd9:    w = off[31:0];
            4'd10:   w = SIGMA2;
            4'd11:   w = key[4];
            4'd12:   w = key[5];
            4'd13:   w = key[6];
            4'd14:   w = key[7];
            default: w = SIGMA3;
        endcase
        return w;
    endfunction

endpackage

### rtl/skx_arx_unit.sv
// ----------------------------------------------------------------------------
// skx_arx_unit
// shared add-rotate-xor datapath: out = rotl(x + y, rot) ^ z
// ----------------------------------------------------------------------------
module skx_arx_unit (
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [31:0] z,
    input  logic [4:0]  rot,
    output logic [31:0] res
);
    logic [31:0] sum;
    logic [31:0] rotated;

    assign sum = x + y;
    // a zero rotate shifts the upper term out entirely
    assign rotated = (sum << rot) | (sum >> (6'd32 - {1'b0, rot}));
    assign res = rotated ^ z;

endmodule

### rtl/skx_state_regs.sv
// ----------------------------------------------------------------------------
// skx_state_regs
// sixteen-word working state; also holds the keystream block once mixed
// ----------------------------------------------------------------------------
module skx_state_regs (
    input  logic             clk,
    input  skx_pkg::ctrl_t   ctrl,
    input  skx_pkg::key_arr_t key,
    input  logic [63:0]      blk_off,
    input  logic [5:0]       pos,
    output logic [7:0]       ks_byte
);
    import skx_pkg::*;

    word_arr_t   s_reg;
    word_arr_t   s_next;
    word_arr_t   t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [4:0]  rot;
    logic [31:0] arx_res;
    logic [31:0] ks_word;

    skx_arx_unit u_arx (
        .x   (x),
        .y   (y),
        .z   (z),
        .rot (rot),
        .res (arx_res)
    );

    // quarter round always works on slots 0, 4, 8, 12 (a, b, c, d)
    always_comb
    begin
        case (ctrl.step)
            STEP_B:
            begin
                x = s_reg[0];  y = s_reg[12]; z = s_reg[4];  rot = ROT_B;
            end
            STEP_C:
            begin
                x = s_reg[4];  y = s_reg[0];  z = s_reg[8];  rot = ROT_C;
            end
            STEP_D:
            begin
                x = s_reg[8];  y = s_reg[4];  z = s_reg[12]; rot = ROT_D;
            end
            default:
            begin
                x = s_reg[12]; y = s_reg[8];  z = s_reg[0];  rot = ROT_A;
            end
        endcase
        if (ctrl.op == OP_FEED)
        begin
            x   = s_reg[0];
            y   = init_word(ctrl.f_idx, key, blk_off);
            z   = '0;
            rot = ROT_NONE;
        end
    end

    always_comb
    begin
        logic [3:0] ii;
        ii     = '0;
        s_next = s_reg;
        t      = s_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    s_next[i] = init_word(4'(i), key, blk_off);
                end
            end
            OP_STEP:
            begin
                case (ctrl.step)
                    STEP_B:  t[4]  = arx_res;
                    STEP_C:  t[8]  = arx_res;
                    STEP_D:  t[12] = arx_res;
                    default: t[0]  = arx_res;
                endcase
                if (ctrl.q_last && ctrl.h_last)
                begin
                    // transpose the slots, offset by one, to swap between column and row frames
                    for (int i = 0; i < 16; i++)
                    begin
                        ii        = 4'(i);
                        s_next[i] = t[{ii[1:0], ii[3:2]} + 4'd1];
                    end
                end
                else if (ctrl.q_last)
                begin
                    // bring the next quarter's words onto slots 0, 4, 8, 12
                    for (int i = 0; i < 16; i++)
                    begin
                        s_next[i] = t[4'(i + 5)];
                    end
                end
                else
                begin
                    s_next = t;
                end
            end
            OP_FEED:
            begin
                // feed-forward add, one word a cycle through slot 0
                for (int i = 0; i < 15; i++)
                begin
                    s_next[i] = s_reg[i + 1];
                end
                s_next[15] = arx_res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    assign ks_word = s_reg[pos[5:2]];
    assign ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];

endmodule

### rtl/skx_seq.sv
// ----------------------------------------------------------------------------
// skx_seq
// sequencer: block load, quarter-round sub-steps, feed-forward, result beat
// ----------------------------------------------------------------------------
module skx_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           need_build,
    input  logic           out_free,
    output logic           in_ready,
    output logic           emit,
    output skx_pkg::ctrl_t ctrl
);
    import skx_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FEED  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    localparam logic [2:0]      QTR_LAST  = 3'd7;
    localparam logic [3:0]      FEED_LAST = 4'd15;
    localparam logic [DR_W-1:0] DR_LAST   = DR_W'(DOUBLE_ROUNDS - 1);

    state_t          state_reg;
    state_t          state_next;
    logic [1:0]      step_reg;
    logic [1:0]      step_next;
    logic [2:0]      qtr_reg;
    logic [2:0]      qtr_next;
    logic [DR_W-1:0] dr_reg;
    logic [DR_W-1:0] dr_next;
    logic [3:0]      ff_reg;
    logic [3:0]      ff_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        qtr_next   = qtr_reg;
        dr_next    = dr_reg;
        ff_next    = ff_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = need_build ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD:
            begin
                state_next = S_ROUND;
                step_next  = '0;
                qtr_next   = '0;
                dr_next    = '0;
                ff_next    = '0;
            end
            S_ROUND:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_A)
                begin
                    qtr_next = qtr_reg + 3'd1;
                    if (qtr_reg == QTR_LAST)
                    begin
                        if (dr_reg == DR_LAST)
                        begin
                            dr_next    = '0;
                            state_next = S_FEED;
                        end
                        else
                        begin
                            dr_next = dr_reg + DR_W'(1);
                        end
                    end
                end
            end
            S_FEED:
            begin
                ff_next = ff_reg + 4'd1;
                if (ff_reg == FEED_LAST)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            qtr_reg   <= '0;
            dr_reg    <= '0;
            ff_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            qtr_reg   <= qtr_next;
            dr_reg    <= dr_next;
            ff_reg    <= ff_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_LOAD:  ctrl.op = OP_LOAD;
            S_ROUND: ctrl.op = OP_STEP;
            S_FEED:  ctrl.op = OP_FEED;
            default: ctrl.op = OP_HOLD;
        endcase
        ctrl.step   = step_reg;
        ctrl.q_last = (step_reg == STEP_A);
        // last quarter of a column or row half
        ctrl.h_last = (qtr_reg[1:0] == 2'b11);
        ctrl.f_idx  = ff_reg;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign emit     = (state_reg == S_EMIT) && out_free;

endmodule

### rtl/salsa_keystream_xor_core.sv
// ----------------------------------------------------------------------------
// salsa_keystream_xor_core: byte-serial salsa keystream xor
// mid-block byte: result registered once the output is free; no input till then
// block-boundary byte: a load, 32*DOUBLE_ROUNDS arx steps, 16 feed-forward steps
// through the single shared add-rotate-xor unit, then the result beat
// async active-low reset: key words and byte offset zero, no beat pending
// ----------------------------------------------------------------------------
`include "salsa_keystream_xor_core_macros.svh"

module salsa_keystream_xor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import skx_pkg::*;

    key_arr_t    key_reg;
    logic [63:0] off_reg;
    logic [63:0] blk_off_reg;
    logic [5:0]  pos_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [63:0] cur_off;
    logic        accept;
    logic        need_build;
    logic        out_free;
    logic        emit;
    logic [7:0]  ks_byte;
    ctrl_t       ctrl;

    assign accept     = in_valid && in_ready;
    assign cur_off    = first ? '0 : off_reg;
    assign need_build = (cur_off[5:0] == 6'd0);
    assign out_free   = !out_valid_reg || out_ready;

    skx_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .need_build (need_build),
        .out_free   (out_free),
        .in_ready   (in_ready),
        .emit       (emit),
        .ctrl       (ctrl)
    );

    skx_state_regs u_state (
        .clk     (clk),
        .ctrl    (ctrl),
        .key     (key_reg),
        .blk_off (blk_off_reg),
        .pos     (pos_reg),
        .ks_byte (ks_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_write)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else if (accept)
        begin
            off_reg <= cur_off + 64'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_off_reg <= cur_off;
            pos_reg     <= cur_off[5:0];
            data_reg    <= data_byte;
        end
        if (emit)
        begin
            out_byte_reg <= data_reg ^ ks_byte;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    `SKX_ASSERT_NXT(a_busy_after_accept, accept, !in_ready, "accepted beat did not block input")
    `SKX_ASSERT_NXT(a_offset_advance, accept, off_reg == $past(cur_off) + 64'd1, "offset step")
    `SKX_ASSERT_IMP(a_out_from_emit, $rose(out_valid), $past(emit), "result beat without emit")

endmodule

### test/tb_salsa_keystream_xor_core.sv
// ----------------------------------------------------------------------------
// tb_salsa_keystream_xor_core
// self-checking bench for the byte-serial salsa keystream xor core: a local
// salsa block predictor gives every cipher byte; directed key and restart
// cases first, then random message traffic under several key settings, all but
// one calm phase with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_salsa_keystream_xor_core;

    timeunit 1ns;
    timeprecision 1ps;

    import skx_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 400;
    localparam int PHASE_ITEMS = 160;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        first     = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data  = 32'h0;

    // predictor state
    key_arr_t    key_reg;
    logic [63:0] stream_pos;
    logic [31:0] ks_word [16];
    logic [31:0] mix [16];

    logic [7:0]  cipher_q [$];
    logic [7:0]  want_byte;

    bit          steady = 1'b0;
    int          errors = 0;
    int          bytes_sent = 0;
    int          bytes_checked = 0;
    int          msg_count = 0;
    int          key_settings = 1;
    int          quiet_cycles = 0;

    salsa_keystream_xor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .first     (first),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic quarter_round(input int a, input int b, input int c, input int d);
        mix[b] = mix[b] ^ rotl32(mix[a] + mix[d], 7);
        mix[c] = mix[c] ^ rotl32(mix[b] + mix[a], 9);
        mix[d] = mix[d] ^ rotl32(mix[c] + mix[b], 13);
        mix[a] = mix[a] ^ rotl32(mix[d] + mix[c], 18);
    endtask

    task automatic build_keystream(input logic [63:0] pos);
        logic [31:0] seed [16];
        int i;
        seed[0]  = SIGMA0;
        seed[5]  = SIGMA1;
        seed[10] = SIGMA2;
        seed[15] = SIGMA3;
        for (i = 0; i < 4; i++)
        begin
            seed[1 + i]  = key_reg[i];
            seed[11 + i] = key_reg[4 + i];
        end
        seed[6] = pos[63:32];
        seed[8] = pos[63:32];
        seed[7] = pos[31:0];
        seed[9] = pos[31:0];
        for (i = 0; i < 16; i++)
            mix[i] = seed[i];
        for (i = 0; i < DOUBLE_ROUNDS; i++)
        begin
            quarter_round(0, 4, 8, 12);
            quarter_round(5, 9, 13, 1);
            quarter_round(10, 14, 2, 6);
            quarter_round(15, 3, 7, 11);
            quarter_round(0, 1, 2, 3);
            quarter_round(5, 6, 7, 4);
            quarter_round(10, 11, 8, 9);
            quarter_round(15, 12, 13, 14);
        end
        // feed-forward
        for (i = 0; i < 16; i++)
            ks_word[i] = mix[i] + seed[i];
    endtask

    task automatic predict_cipher(input logic [7:0] d, input logic f, output logic [7:0] c);
        logic [5:0]  slot;
        logic [31:0] w;
        if (f)
            stream_pos = 64'd0;
        slot = stream_pos[5:0];
        if (slot == 6'd0)
            build_keystream(stream_pos);
        w = ks_word[slot[5:2]] >> (slot[1:0] * 8);
        c = d ^ w[7:0];
        stream_pos = stream_pos + 64'd1;
    endtask

    task automatic send_beat(input logic [7:0] d, input logic f);
        logic [7:0] c;
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= d;
        first     <= f;
        do
            @(posedge clk);
        while (!in_ready);
        predict_cipher(d, f, c);
        cipher_q.push_back(c);
        bytes_sent++;
    endtask

    // wait until every expected byte has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // only called while the core is idle
    task automatic load_key(input key_arr_t k, input logic [7:0] mask);
        int i;
        for (i = 0; i < 8; i++)
        begin
            if (mask[i])
            begin
                @(negedge clk);
                cfg_write <= 1'b1;
                cfg_index <= 3'(i);
                cfg_data  <= k[i];
                key_reg[i] = k[i];
            end
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        key_settings++;
    endtask

    function automatic key_arr_t random_key();
        key_arr_t k;
        for (int i = 0; i < 8; i++)
            k[i] = $urandom();
        return k;
    endfunction

    task automatic test_reset_key();
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'h5A, 1'b0);
        msg_count += 2;
        drain();
    endtask

    task automatic test_key_extremes();
        load_key({8{32'hFFFF_FFFF}}, 8'hFF);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h55, 1'b0);
        msg_count++;
        drain();
    endtask

    task automatic test_restart_every_byte();
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h80, 1'b1);
        msg_count += 3;
        drain();
    endtask

    // new key must not disturb the block in use, only the next one
    task automatic test_midblock_key_swap();
        int i;
        load_key(random_key(), 8'hFF);
        for (i = 0; i < 6; i++)
            send_beat(8'($urandom_range(0, 255)), i == 0);
        drain();
        load_key(random_key(), 8'b0010_0100);
        for (i = 0; i < 4; i++)
            send_beat(8'($urandom_range(0, 255)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        send_beat(8'($urandom_range(0, 255)), 1'b0);
        msg_count += 2;
        drain();
    endtask

    task automatic test_random_traffic(input key_arr_t k, input int target, input bit calm);
        int  count;
        int  len;
        int  pick;
        int  j;
        bit  carry_on;
        load_key(k, 8'hFF);
        steady = calm;
        count  = 0;
        while (count < target)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(1, 40);
                else if (pick < 95)
                    len = $urandom_range(41, 140);
                else
                    len = $urandom_range(141, 260);
                // sometimes keep the previous message going under the new key
                carry_on = (count == 0) && ($urandom_range(0, 1) == 1);
                for (j = 0; j < len; j++)
                    send_beat(8'($urandom_range(0, 255)), (j == 0) && !carry_on);
                count += len;
                msg_count++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (j = 0; j < len; j++)
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                count += len;
            end
        end
        drain();
        steady = 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_q.size() == 0)
            begin
                $error("out_byte beat with nothing expected: actual %02h", out_byte);
                errors++;
            end
            else
            begin
                want_byte = cipher_q.pop_front();
                if (out_byte !== want_byte)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h", want_byte, out_byte);
                    errors++;
                end
                bytes_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        key_reg    = '0;
        stream_pos = 64'd0;
        for (int i = 0; i < 16; i++)
            ks_word[i] = 32'h0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_key();
        test_key_extremes();
        test_restart_every_byte();
        test_midblock_key_swap();

        test_random_traffic('0, PHASE_ITEMS, 1'b0);
        test_random_traffic({8{32'hFFFF_FFFF}}, PHASE_ITEMS, 1'b0);
        test_random_traffic(random_key(), PHASE_ITEMS, 1'b1);
        test_random_traffic({4{32'h0000_0001, 32'h8000_0000}}, PHASE_ITEMS, 1'b0);
        test_random_traffic(random_key(), PHASE_ITEMS, 1'b0);
        test_random_traffic(random_key(), PHASE_ITEMS, 1'b0);

        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d bytes in about %0d messages, checked %0d cipher bytes",
                 bytes_sent, msg_count, bytes_checked);
        $display("key settings used: %0d, mismatches: %0d", key_settings, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/skx_pkg.sv
rtl/skx_arx_unit.sv
rtl/skx_state_regs.sv
rtl/skx_seq.sv
rtl/salsa_keystream_xor_core.sv
test/tb_salsa_keystream_xor_core.sv
